FILE: src/elevator_scan_controller_defines.svh
// assertion macros shared by the elevator scan controller rtl
`ifndef ELEVATOR_SCAN_CONTROLLER_DEFINES_SVH
`define ELEVATOR_SCAN_CONTROLLER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// checked on every edge out of reset
`define ESC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define ESC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ESC_ASSERT(lbl, prop, msg)

`define ESC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

FILE: src/esc_pkg.sv
package esc_pkg;

  // item opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_REQ  = 1'b1;

  // mode codes as reported on the result
  localparam logic [1:0] MODE_SAME = 2'd0;
  localparam logic [1:0] MODE_OPP  = 2'd1;
  localparam logic [1:0] MODE_REV  = 2'd2;

  typedef enum logic [2:0] {
    CTRL_SAME = 3'b001,
    CTRL_OPP  = 3'b010,
    CTRL_REV  = 3'b100
  } ctrl_t;

  typedef struct packed {
    logic       op;
    logic [7:0] up_mask;
    logic [7:0] down_mask;
  } cmd_t;

  typedef struct packed {
    logic [2:0] car_floor;
    logic       heading_up;
    logic [1:0] mode;
    logic       moved;
    logic [7:0] pending_up;
    logic [7:0] pending_down;
  } res_t;

  typedef struct packed {
    logic [7:0] up_req;
    logic [7:0] down_req;
    logic [2:0] position;
    logic       going_up;
    ctrl_t      ctrl;
  } car_state_t;

  function automatic logic [1:0] mode_code(ctrl_t c);
    logic [1:0] m;
    case (c)
      CTRL_SAME: m = MODE_SAME;
      CTRL_OPP:  m = MODE_OPP;
      default:   m = MODE_REV;
    endcase
    return m;
  endfunction

endpackage

FILE: src/esc_step.sv
module esc_step import esc_pkg::*; #(
  parameter int SPAN = 8
) (
  input  cmd_t       cmd,
  input  car_state_t cur,
  output car_state_t nxt,
  output logic       moved
);

  localparam int         FM_INT     = (1 << SPAN) - 1;
  localparam logic [7:0] FLOOR_MASK = 8'(FM_INT);
  localparam logic [3:0] SPAN_W     = 4'(SPAN);

  logic [7:0] above_mask;
  logic [7:0] below_mask;
  logic [7:0] same;
  logic [7:0] opp;
  logic       act;
  logic [3:0] pos_inc;
  logic [2:0] new_pos;
  logic       can_move;
  logic [7:0] clr;

  always_comb begin
    pos_inc    = {1'b0, cur.position} + 4'd1;
    above_mask = (8'hFF << pos_inc) & FLOOR_MASK;
    below_mask = ~(8'hFF << cur.position);
    same = cur.going_up ? (cur.up_req & above_mask) : (cur.down_req & below_mask);
    opp  = cur.going_up ? (cur.down_req & above_mask) : (cur.up_req & below_mask);

    // car can only leave if it stays inside the shaft
    if (cur.going_up) begin
      can_move = pos_inc < SPAN_W;
      new_pos  = pos_inc[2:0];
    end else begin
      can_move = cur.position != 3'd0;
      new_pos  = cur.position - 3'd1;
    end
    clr = ~(8'd1 << new_pos);

    nxt   = cur;
    moved = 1'b0;
    act   = 1'b1;

    if (cmd.op == OP_REQ) begin
      nxt.up_req   = (cur.up_req | cmd.up_mask) & FLOOR_MASK;
      nxt.down_req = (cur.down_req | cmd.down_mask) & FLOOR_MASK;
    end else begin
      case (cur.ctrl)
        CTRL_SAME: begin
          if (same == 8'd0) begin
            nxt.ctrl = CTRL_OPP;
            act      = 1'b0;
          end
        end
        CTRL_OPP: begin
          if (opp == 8'd0) begin
            nxt.ctrl = CTRL_REV;
          end
        end
        default: begin
          // opposite-direction requests win over same-direction ones
          if (opp != 8'd0) begin
            nxt.ctrl = CTRL_OPP;
          end else if (same != 8'd0) begin
            nxt.ctrl = CTRL_SAME;
          end else begin
            nxt.ctrl = CTRL_REV;
          end
        end
      endcase

      if (act) begin
        if (nxt.ctrl == CTRL_REV) begin
          nxt.going_up = ~cur.going_up;
        end else if (can_move) begin
          moved        = 1'b1;
          nxt.position = new_pos;
          nxt.up_req   = cur.up_req & clr;
          nxt.down_req = cur.down_req & clr;
        end
      end
    end
  end

endmodule

FILE: src/elevator_scan_controller.sv
// SCAN elevator scheduler. Request items (op=1) OR floor bits into the pending
// up and down masks; tick items (op=0) run one controller step: a possible mode
// change, then a one-floor move (if the car stays inside the shaft) or a direction
// flip, except that a switch from same-direction to opposite service takes the
// whole step. Every item gives exactly one result carrying the car state after
// that item. An item is registered in the stage register on entry, worked there by
// one pass of priority-mask logic against the car state, and written to the result
// register, so one item is taken per cycle while the result side does not stall.
// Only floors below min(FLOORS, 8) are tracked. After reset the car sits at floor 0 heading up in reverse mode.
`include "elevator_scan_controller_defines.svh"

module elevator_scan_controller import esc_pkg::*; #(
  parameter int FLOORS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  localparam int         SPAN       = (FLOORS > 8) ? 8 : FLOORS;
  localparam int         FM_INT     = (1 << SPAN) - 1;
  localparam logic [7:0] FLOOR_MASK = 8'(FM_INT);

  logic       stage_valid;
  cmd_t       stage_cmd;
  logic       stage_go;
  logic       cmd_take;
  car_state_t state;
  car_state_t state_next;
  logic       moved_next;

  assign stage_go  = stage_valid && (!res_valid || !res_stall);
  assign cmd_stall = stage_valid && !stage_go;
  assign cmd_take  = cmd_valid && !cmd_stall;

  esc_step #(
    .SPAN(SPAN)
  ) u_step (
    .cmd   (stage_cmd),
    .cur   (state),
    .nxt   (state_next),
    .moved (moved_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (cmd_take) begin
      stage_valid <= 1'b1;
    end else if (stage_go) begin
      stage_valid <= 1'b0;
    end
    if (cmd_take) begin
      stage_cmd <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.up_req   <= 8'd0;
      state.down_req <= 8'd0;
      state.position <= 3'd0;
      state.going_up <= 1'b1;
      state.ctrl     <= CTRL_REV;
    end else if (stage_go) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (stage_go) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
    if (stage_go) begin
      res.car_floor    <= state_next.position;
      res.heading_up   <= state_next.going_up;
      res.mode         <= mode_code(state_next.ctrl);
      res.moved        <= moved_next;
      res.pending_up   <= state_next.up_req;
      res.pending_down <= state_next.down_req;
    end
  end

  `ESC_ASSERT(a_stall_only_when_full, cmd_stall |-> stage_valid,
              "input stalled with an empty stage")
  `ESC_ASSERT(a_move_not_in_reverse,
              (res_valid && res.moved) |-> (res.mode != MODE_REV),
              "car moved in reverse mode")
  `ESC_ASSERT(a_move_changes_floor,
              (stage_go && moved_next) |=> (state.position != $past(state.position)),
              "move left the car on the same floor")
  `ESC_ASSERT(a_no_requests_off_shaft,
              ((state.up_req | state.down_req) & ~FLOOR_MASK) == 8'd0,
              "request stored beyond the shaft")
  `ESC_ASSERT_ALWAYS(a_reset_state,
                     $past(rst) |-> (state.ctrl == CTRL_REV && state.position == 3'd0
                                     && !res_valid),
                     "wrong state after reset")

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import esc_pkg::*;

  localparam int FLOOR_SPAN = 8;
  localparam logic [7:0] FLOOR_BITS = 8'((9'd1 << FLOOR_SPAN) - 9'd1);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  cmd_t pending_cmds[$];
  res_t expected_res[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int err_count = 0;

  // car state as the scheduler should see it
  logic [7:0] up_pend;
  logic [7:0] down_pend;
  logic [2:0] car_pos;
  logic car_up;
  logic [1:0] car_mode;

  elevator_scan_controller DUT (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] floors_above(logic [7:0] m);
    logic [8:0] upto;
    upto = (9'd2 << car_pos) - 9'd1;
    return m & ~upto[7:0] & FLOOR_BITS;
  endfunction

  function automatic logic [7:0] floors_below(logic [7:0] m);
    return m & ((8'd1 << car_pos) - 8'd1);
  endfunction

  function automatic logic move_car();
    if (car_up) begin
      if (int'(car_pos) + 1 >= FLOOR_SPAN) return 1'b0;
      car_pos = car_pos + 3'd1;
    end else begin
      if (car_pos == 3'd0) return 1'b0;
      car_pos = car_pos - 3'd1;
    end
    // arriving serves both directions at the new floor
    up_pend = up_pend & ~(8'd1 << car_pos);
    down_pend = down_pend & ~(8'd1 << car_pos);
    return 1'b1;
  endfunction

  function automatic res_t step_car(cmd_t c);
    logic [7:0] same;
    logic [7:0] opp;
    logic did_move;
    logic act;
    res_t r;
    did_move = 1'b0;
    act = 1'b1;
    if (c.op == OP_REQ) begin
      up_pend = (up_pend | c.up_mask) & FLOOR_BITS;
      down_pend = (down_pend | c.down_mask) & FLOOR_BITS;
    end else begin
      same = car_up ? floors_above(up_pend) : floors_below(down_pend);
      opp = car_up ? floors_above(down_pend) : floors_below(up_pend);
      case (car_mode)
        MODE_SAME: begin
          // switching to opposite service uses up the whole tick
          if (same == 8'd0) begin
            car_mode = MODE_OPP;
            act = 1'b0;
          end
        end
        MODE_OPP: begin
          if (opp == 8'd0) car_mode = MODE_REV;
        end
        default: begin
          car_mode = MODE_REV;
          if (same != 8'd0) car_mode = MODE_SAME;
          if (opp != 8'd0) car_mode = MODE_OPP;
        end
      endcase
      if (act) begin
        if (car_mode == MODE_REV) car_up = ~car_up;
        else did_move = move_car();
      end
    end
    r.car_floor = car_pos;
    r.heading_up = car_up;
    r.mode = car_mode;
    r.moved = did_move;
    r.pending_up = up_pend;
    r.pending_down = down_pend;
    return r;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int pick;
    int sel;
    c.up_mask = 8'($urandom);
    c.down_mask = 8'($urandom);
    c.op = OP_REQ;
    pick = $urandom_range(99);
    if (pick < 65) begin
      c.op = OP_TICK;
    end else if (pick < 82) begin
      // single hall call up, down or one of each, the common case
      sel = $urandom_range(2);
      c.up_mask = (sel != 1) ? 8'd1 << $urandom_range(7) : 8'd0;
      c.down_mask = (sel != 0) ? 8'd1 << $urandom_range(7) : 8'd0;
    end else if (pick >= 95) begin
      c.up_mask = (pick < 98) ? 8'h00 : 8'hFF;
      c.down_mask = c.up_mask;
    end
    return c;
  endfunction

  task automatic push_req(logic [7:0] up_bits, logic [7:0] down_bits);
    cmd_t c;
    c.op = OP_REQ;
    c.up_mask = up_bits;
    c.down_mask = down_bits;
    pending_cmds.push_back(c);
  endtask

  task automatic push_ticks(int count);
    cmd_t c;
    for (int i = 0; i < count; i++) begin
      c.op = OP_TICK;
      c.up_mask = 8'($urandom);
      c.down_mask = 8'($urandom);
      pending_cmds.push_back(c);
    end
  endtask

  task automatic push_random(int count);
    for (int i = 0; i < count; i++) pending_cmds.push_back(random_cmd());
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || cmd_valid || expected_res.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_val, act_val);
      err_count++;
    end
  endtask

  // driver: predicts on acceptance, then offers the next item or idles
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      cmd <= '0;
      up_pend = 8'd0;
      down_pend = 8'd0;
      car_pos = 3'd0;
      car_up = 1'b1;
      car_mode = MODE_REV;
    end else begin
      if (cmd_valid && !cmd_stall) expected_res.push_back(step_car(cmd));
      if (!cmd_valid || !cmd_stall) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd <= pending_cmds.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: result side stall and compare
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_res.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %0h", $time, res);
          err_count++;
        end else begin
          res_t exp_r;
          exp_r = expected_res.pop_front();
          check_field("car_floor", 8'(exp_r.car_floor), 8'(res.car_floor));
          check_field("heading_up", 8'(exp_r.heading_up), 8'(res.heading_up));
          check_field("mode", 8'(exp_r.mode), 8'(res.mode));
          check_field("moved", 8'(exp_r.moved), 8'(res.moved));
          check_field("pending_up", exp_r.pending_up, res.pending_up);
          check_field("pending_down", exp_r.pending_down, res.pending_down);
        end
      end
      res_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 23;
    recv_stall_pct = 86;
    // empty car just flips direction
    push_ticks(2);
    // calls at the car's own floor stay stored
    push_req(8'h01, 8'h01);
    push_ticks(2);
    // run to the top floor, then give up and reverse
    push_req(8'h80, 8'h00);
    push_ticks(9);
    // every floor at once, from the top heading down
    push_req(8'hFF, 8'h00);
    push_ticks(4);
    push_req(8'h00, 8'hFF);
    push_ticks(3);
    push_random(470);
    drain();

    send_idle_pct = 86;
    recv_stall_pct = 23;
    push_random(470);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    push_random(460);
    drain();

    repeat (10) @(posedge clk);
    if (expected_res.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_res.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

endmodule
